[rtl/apap_pkg.sv]
package apap_pkg;

	localparam int HEADER_BYTES = 11;
	localparam int RECORD_BYTES = 4;
	localparam int NAME_BYTES = 8;
	localparam int MODEL_END = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [4:0] {
		PH_FCODE  = 5'b00001,
		PH_COUNT  = 5'b00010,
		PH_HEADER = 5'b00100,
		PH_RECORD = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef enum logic {
		KIND_ENTRY = 1'b0,
		KIND_END   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] unit_name;
		logic [15:0] model_code;
		logic [15:0] function_object_id;
		logic [15:0] input_object_id;
		logic        verdict;
	} result_t;

endpackage

[rtl/apap_queue.sv]
module apap_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   push_n,
	input  apap_pkg::result_t            push_d0,
	input  apap_pkg::result_t            push_d1,
	output logic                         has_room,
	output logic                         head_valid,
	input  logic                         head_pop,
	output apap_pkg::result_t            head_d
);

	apap_pkg::result_t                   slot_q [apap_pkg::QUEUE_DEPTH];
	logic [apap_pkg::PTR_W-1:0]          wr_ptr_q;
	logic [apap_pkg::PTR_W-1:0]          rd_ptr_q;
	logic [apap_pkg::CNT_W-1:0]          count_q;
	logic                                pop;
	logic [apap_pkg::PTR_W-1:0]          wr_ptr_p1;

	assign head_valid = (count_q != '0);
	assign has_room = (count_q <= apap_pkg::CNT_W'(apap_pkg::QUEUE_DEPTH - 2));
	assign pop = head_valid & head_pop;
	assign head_d = slot_q[rd_ptr_q];
	assign wr_ptr_p1 = wr_ptr_q + apap_pkg::PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			slot_q[wr_ptr_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			slot_q[wr_ptr_p1] <= push_d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + apap_pkg::PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + apap_pkg::PTR_W'(1);
			end
			count_q <= count_q + apap_pkg::CNT_W'(push_n) - apap_pkg::CNT_W'(pop);
		end
	end

endmodule

[rtl/aux_preferred_assignment_parser_unit.sv]
// Auxiliary preferred-assignment parser.
// The input channel (in_valid, in_ready, data_byte, last_byte) takes one message
// byte per word; last_byte marks the final byte of a message. The output channel
// (out_valid, out_ready and the result fields) gives one assignment entry per
// completed function record, and one end word with the verdict after the final
// byte. When the verdict says malformed, the receiver drops that message's entries.
// The parser state is updated in the cycle a byte is accepted, and its results
// enter a four-word output queue, whose head offers them to the receiver in order.
// One byte is accepted per cycle while the queue holds at most two words, so
// the sustained rate is one byte per cycle while the receiver keeps up; a final
// byte that completes a record yields two words, which leave the queue in turn.
// When the receiver stalls, the queue fills and in_ready drops until it holds
// at most two words again. Reset clears the parser, so the next byte is taken
// as a function code, and empties the queue.
module aux_preferred_assignment_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        item_kind,
	output logic [63:0] unit_name,
	output logic [15:0] model_code,
	output logic [15:0] function_object_id,
	output logic [15:0] input_object_id,
	output logic        verdict,
	output logic        final_item
);

	apap_pkg::phase_t   phase_q, phase_d;
	logic [3:0]         index_q, index_d;
	logic [7:0]         units_q, units_d;
	logic [7:0]         funcs_q, funcs_d;
	logic [63:0]        name_q, name_d;
	logic [15:0]        model_q, model_d;
	logic [31:0]        record_q, record_d;
	logic               accept;
	logic               entry_done;
	logic [1:0]         push_n;
	apap_pkg::result_t  entry_r, end_r, push_d0;
	apap_pkg::result_t  head_d;

	assign accept = in_valid & in_ready;

	always_comb begin
		phase_d = phase_q;
		index_d = index_q;
		units_d = units_q;
		funcs_d = funcs_q;
		name_d = name_q;
		model_d = model_q;
		record_d = record_q;
		entry_done = 1'b0;
		case (phase_q)
			apap_pkg::PH_FCODE: begin
				phase_d = apap_pkg::PH_COUNT;
			end
			apap_pkg::PH_COUNT: begin
				units_d = data_byte;
				index_d = '0;
				phase_d = (data_byte == 8'd0) ? apap_pkg::PH_DONE : apap_pkg::PH_HEADER;
			end
			apap_pkg::PH_HEADER: begin
				if (index_q < 4'(apap_pkg::NAME_BYTES)) begin
					name_d = {data_byte, name_q[63:8]};
				end else if (index_q < 4'(apap_pkg::MODEL_END)) begin
					model_d = {data_byte, model_q[15:8]};
				end
				if (index_q >= 4'(apap_pkg::HEADER_BYTES - 1)) begin
					funcs_d = data_byte;
					index_d = '0;
					if (data_byte == 8'd0) begin
						units_d = units_q - 8'd1;
						phase_d = (units_d == 8'd0) ? apap_pkg::PH_DONE
							: apap_pkg::PH_HEADER;
					end else begin
						phase_d = apap_pkg::PH_RECORD;
					end
				end else begin
					index_d = index_q + 4'd1;
				end
			end
			apap_pkg::PH_RECORD: begin
				record_d = {data_byte, record_q[31:8]};
				if (index_q >= 4'(apap_pkg::RECORD_BYTES - 1)) begin
					entry_done = 1'b1;
					index_d = '0;
					funcs_d = funcs_q - 8'd1;
					if (funcs_d == 8'd0) begin
						units_d = units_q - 8'd1;
						phase_d = (units_d == 8'd0) ? apap_pkg::PH_DONE
							: apap_pkg::PH_HEADER;
					end
				end else begin
					index_d = index_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		entry_r.kind = apap_pkg::KIND_ENTRY;
		entry_r.unit_name = name_d;
		entry_r.model_code = model_d;
		entry_r.function_object_id = record_d[15:0];
		entry_r.input_object_id = record_d[31:16];
		entry_r.verdict = 1'b0;
		end_r.kind = apap_pkg::KIND_END;
		end_r.unit_name = '0;
		end_r.model_code = '0;
		end_r.function_object_id = '0;
		end_r.input_object_id = '0;
		end_r.verdict = (phase_d != apap_pkg::PH_DONE);
		push_d0 = entry_done ? entry_r : end_r;
		if (!accept) begin
			push_n = 2'd0;
		end else begin
			push_n = 2'(entry_done) + 2'(last_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= apap_pkg::PH_FCODE;
			index_q <= '0;
			units_q <= '0;
			funcs_q <= '0;
			name_q <= '0;
			model_q <= '0;
			record_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q <= apap_pkg::PH_FCODE;
				index_q <= '0;
				units_q <= '0;
				funcs_q <= '0;
				name_q <= '0;
				model_q <= '0;
				record_q <= '0;
			end else begin
				phase_q <= phase_d;
				index_q <= index_d;
				units_q <= units_d;
				funcs_q <= funcs_d;
				name_q <= name_d;
				model_q <= model_d;
				record_q <= record_d;
			end
		end
	end

	apap_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_d0    (push_d0),
		.push_d1    (end_r),
		.has_room   (in_ready),
		.head_valid (out_valid),
		.head_pop   (out_ready),
		.head_d     (head_d)
	);

	assign item_kind = head_d.kind;
	assign unit_name = head_d.unit_name;
	assign model_code = head_d.model_code;
	assign function_object_id = head_d.function_object_id;
	assign input_object_id = head_d.input_object_id;
	assign verdict = head_d.verdict;
	assign final_item = head_d.kind;

endmodule

[dv/apap_result_checker.sv]
`timescale 1ns / 100ps

module apap_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        item_kind,
	input  logic [63:0] unit_name,
	input  logic [15:0] model_code,
	input  logic [15:0] function_object_id,
	input  logic [15:0] input_object_id,
	input  logic        verdict,
	input  logic        final_item,
	output int          failures,
	output int          pending
);

	apap_pkg::phase_t parse_phase;
	logic [3:0]  byte_idx;
	logic [7:0]  units_left;
	logic [7:0]  funcs_left;
	logic [63:0] name_acc;
	logic [15:0] model_acc;
	logic [31:0] record_acc;

	apap_pkg::result_t expected_words[$];
	apap_pkg::result_t want;

	task automatic append_word(input apap_pkg::result_t w);
		expected_words.insert(expected_words.size(), w);
	endtask

	task automatic clear_parser();
		parse_phase = apap_pkg::PH_FCODE;
		byte_idx = '0;
		units_left = '0;
		funcs_left = '0;
		name_acc = '0;
		model_acc = '0;
		record_acc = '0;
	endtask

	task automatic finish_unit();
		units_left = units_left - 8'd1;
		byte_idx = '0;
		parse_phase = (units_left == 8'd0) ? apap_pkg::PH_DONE : apap_pkg::PH_HEADER;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		apap_pkg::result_t w;
		case (parse_phase)
			apap_pkg::PH_FCODE: begin
				parse_phase = apap_pkg::PH_COUNT;
			end
			apap_pkg::PH_COUNT: begin
				units_left = b;
				byte_idx = '0;
				parse_phase = (b == 8'd0) ? apap_pkg::PH_DONE : apap_pkg::PH_HEADER;
			end
			apap_pkg::PH_HEADER: begin
				if (byte_idx < 4'(apap_pkg::NAME_BYTES)) begin
					name_acc = {b, name_acc[63:8]};
				end else if (byte_idx < 4'(apap_pkg::MODEL_END)) begin
					model_acc = {b, model_acc[15:8]};
				end
				if (byte_idx >= 4'(apap_pkg::HEADER_BYTES - 1)) begin
					funcs_left = b;
					byte_idx = '0;
					if (b == 8'd0) begin
						finish_unit();
					end else begin
						parse_phase = apap_pkg::PH_RECORD;
					end
				end else begin
					byte_idx = byte_idx + 4'd1;
				end
			end
			apap_pkg::PH_RECORD: begin
				record_acc = {b, record_acc[31:8]};
				if (byte_idx >= 4'(apap_pkg::RECORD_BYTES - 1)) begin
					w = '0;
					w.kind = apap_pkg::KIND_ENTRY;
					w.unit_name = name_acc;
					w.model_code = model_acc;
					w.function_object_id = record_acc[15:0];
					w.input_object_id = record_acc[31:16];
					append_word(w);
					byte_idx = '0;
					funcs_left = funcs_left - 8'd1;
					if (funcs_left == 8'd0) begin
						finish_unit();
					end
				end else begin
					byte_idx = byte_idx + 4'd1;
				end
			end
			default: begin
			end
		endcase
		if (last) begin
			w = '0;
			w.kind = apap_pkg::KIND_END;
			w.verdict = (parse_phase != apap_pkg::PH_DONE);
			append_word(w);
			clear_parser();
		end
	endtask

	function automatic int field_differs(input string label, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %h, actual %h", $time, label, want_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_words.delete();
			failures = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual kind %0d verdict %0d",
						$time, item_kind, verdict);
					failures = failures + 1;
				end else begin
					want = expected_words.pop_front();
					failures = failures
						+ field_differs("item_kind", 64'(want.kind), 64'(item_kind))
						+ field_differs("unit_name", want.unit_name, unit_name)
						+ field_differs("model_code", 64'(want.model_code),
							64'(model_code))
						+ field_differs("function_object_id",
							64'(want.function_object_id), 64'(function_object_id))
						+ field_differs("input_object_id", 64'(want.input_object_id),
							64'(input_object_id))
						+ field_differs("verdict", 64'(want.verdict), 64'(verdict))
						+ field_differs("final_item",
							64'(want.kind == apap_pkg::KIND_END), 64'(final_item));
				end
			end
			if (in_valid && in_ready) begin
				parse_byte(data_byte, last_byte);
			end
		end
		pending = expected_words.size();
	end

endmodule

[dv/aux_preferred_assignment_parser_unit_test.sv]
`timescale 1ns / 100ps

module aux_preferred_assignment_parser_unit_test;

	localparam int BYTE_TARGET = 1700;
	localparam int IDLE_LIMIT = 5000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        item_kind;
	logic [63:0] unit_name;
	logic [15:0] model_code;
	logic [15:0] function_object_id;
	logic [15:0] input_object_id;
	logic        verdict;
	logic        final_item;

	int failures;
	int pending;
	int bytes_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int ready_mode = 0;
	int mode_left = 0;
	int stall_left = 0;

	logic [7:0] msg_bytes[$];

	aux_preferred_assignment_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.unit_name(unit_name),
		.model_code(model_code),
		.function_object_id(function_object_id),
		.input_object_id(input_object_id),
		.verdict(verdict),
		.final_item(final_item)
	);

	apap_result_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.unit_name(unit_name),
		.model_code(model_code),
		.function_object_id(function_object_id),
		.input_object_id(input_object_id),
		.verdict(verdict),
		.final_item(final_item),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(32, 256);
		end else begin
			mode_left = mode_left - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 9) != 0);
			default: begin
				if (stall_left > 0) begin
					stall_left = stall_left - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(1, 20);
					end
				end
			end
		endcase
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles = idle_cycles + 1;
			end
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic append_byte(input logic [7:0] b);
		msg_bytes.insert(msg_bytes.size(), b);
	endtask

	task automatic send_word(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left = burst_left - 1;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (!in_ready);
		bytes_sent = bytes_sent + 1;
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++) begin
			send_word(msg_bytes[i], i == msg_bytes.size() - 1);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Builds a message in msg_bytes; stops early once the cap is reached.
	task automatic build_message(input int units, input int fn_min, input int fn_max,
			input int cap);
		int fn;
		msg_bytes.delete();
		append_byte(8'($urandom_range(0, 255)));
		append_byte(8'(units));
		for (int u = 0; u < units; u++) begin
			for (int k = 0; k < 10; k++) begin
				if (msg_bytes.size() >= cap) return;
				append_byte(8'($urandom_range(0, 255)));
			end
			fn = $urandom_range(fn_min, fn_max);
			append_byte(8'(fn));
			for (int f = 0; f < fn * 4; f++) begin
				if (msg_bytes.size() >= cap) return;
				append_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic random_message();
		int pick;
		int cut;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			build_message($urandom_range(0, 3), 0, 3, 1 << 20);
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
			end
		end else if (pick < 75) begin
			build_message($urandom_range(1, 3), 0, 3, 1 << 20);
			cut = $urandom_range(2, msg_bytes.size() - 1);
			while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
		end else if (pick < 85) begin
			msg_bytes.delete();
			append_byte(8'($urandom_range(0, 255)));
		end else if (pick < 95) begin
			msg_bytes.delete();
			repeat ($urandom_range(1, 24)) append_byte(8'($urandom_range(0, 255)));
		end else if (pick < 98) begin
			build_message(255, 0, 1, $urandom_range(30, 60));
		end else begin
			build_message(1, 255, 255, $urandom_range(30, 60));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Message that ends on its function code.
		msg_bytes = '{8'h00};
		send_message();
		// No units, then no units with a trailing byte.
		msg_bytes = '{8'hff, 8'h00};
		send_message();
		msg_bytes = '{8'h00, 8'h00, 8'hff};
		send_message();
		// One unit with one record, all ones, the final byte closing the record.
		msg_bytes = '{8'hff, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
			8'hff, 8'hff, 8'hff, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff};
		send_message();
		wait_for_results();

		while (bytes_sent < BYTE_TARGET) begin
			random_message();
			send_message();
			if ($urandom_range(0, 29) == 0) begin
				wait_for_results();
			end
		end

		wait_for_results();
		repeat (10) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[files.f]
rtl/apap_pkg.sv
rtl/apap_queue.sv
rtl/aux_preferred_assignment_parser_unit.sv
dv/apap_result_checker.sv
dv/aux_preferred_assignment_parser_unit_test.sv
